FILE: src/pswwm_pkg.sv
// shared types, constants and helpers for the periodic seed window weight block
package pswwm_pkg;

   localparam int MAX_BLOCK   = 32;
   localparam int MAX_READ    = 255;
   localparam int QUEUE_DEPTH = 2;
   localparam int PAT_W       = 64;
   localparam int BLEN_W      = 6;
   localparam int RLEN_W      = 8;
   localparam int WT_W        = 10;
   localparam int POS_W       = 5;
   localparam int TOTAL_W     = 7;
   localparam logic [BLEN_W-1:0] BLEN_RESET = 6'd4;

   typedef enum logic [1:0] {
      F_IDLE,
      F_CALC,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_INIT,
      B_SLIDE,
      B_READ,
      B_UPD
   } back_state_type;

   typedef struct packed {
      logic [PAT_W-1:0]   weights;
      logic [BLEN_W-1:0]  blen;
      logic [RLEN_W-1:0]  full;
      logic [POS_W-1:0]   rem;
      logic [TOTAL_W-1:0] total;
      logic [RLEN_W-1:0]  rlen;
      logic               ok;
      logic               in_range;
   } job_type;

   function automatic logic [PAT_W-1:0] swap_codes(input logic [PAT_W-1:0] pat);
      logic [PAT_W-1:0] res;
      for (int k = 0; k < PAT_W / 2; k++) begin
         res[2*k]   = pat[2*k+1];
         res[2*k+1] = pat[2*k];
      end
      return res;
   endfunction

   function automatic logic [1:0] weight_at(input logic [PAT_W-1:0] w,
                                            input logic [POS_W-1:0] idx);
      return w[{idx, 1'b0} +: 2];
   endfunction

endpackage

FILE: src/pswwm_fifo.sv
// short job queue between the front and back parts
module pswwm_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pswwm_pkg::job_type push_data,
   input  logic              pop,
   output pswwm_pkg::job_type pop_data,
   output logic              full,
   output logic              empty
);

   localparam int DEPTH = pswwm_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pswwm_pkg::job_type store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("job queue overflow");

endmodule

FILE: src/pswwm_front.sv
// front part: takes items, decodes the block, sums its weight and divides the span
module pswwm_front #(
   parameter int MAX_READ = pswwm_pkg::MAX_READ
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          hold,
   input  logic [pswwm_pkg::BLEN_W-1:0]  block_len,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [pswwm_pkg::PAT_W-1:0]   pattern,
   input  logic [pswwm_pkg::RLEN_W-1:0]  read_len,
   output logic                          push,
   output pswwm_pkg::job_type            push_data,
   input  logic                          queue_full
);

   localparam int BW = pswwm_pkg::BLEN_W;
   localparam int PW = pswwm_pkg::POS_W;
   localparam int TW = pswwm_pkg::TOTAL_W;
   localparam int RW = pswwm_pkg::RLEN_W;

   pswwm_pkg::front_state_type state_ff, state_in;

   logic [pswwm_pkg::PAT_W-1:0] pat_ff, pat_in;
   logic [RW-1:0] rlen_ff, rlen_in;
   logic [BW-1:0] blen_ff, blen_in;
   logic [TW-1:0] total_ff, total_in;
   logic [PW-1:0] cnt_ff, cnt_in;
   logic [PW-1:0] last_ff, last_in;
   logic [PW-1:0] rem_ff, rem_in;
   logic [RW-1:0] quo_ff, quo_in;
   logic [RW-1:0] div_ff, div_in;
   logic          ok_ff, ok_in;
   logic          range_ff, range_in;

   logic          take;
   logic [BW-1:0] eff_blen;
   logic [RW:0]   span;
   logic          in_range;
   logic [BW:0]   rtmp;
   logic          ge;

   assign take = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pswwm_pkg::F_IDLE: begin
            if (take) state_in = pswwm_pkg::F_CALC;
         end
         pswwm_pkg::F_CALC: begin
            if (cnt_ff == last_ff) state_in = pswwm_pkg::F_PUSH;
         end
         pswwm_pkg::F_PUSH: begin
            if (!queue_full) state_in = pswwm_pkg::F_IDLE;
         end
         default: state_in = pswwm_pkg::F_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == pswwm_pkg::F_IDLE) && !hold;
      push       = (state_ff == pswwm_pkg::F_PUSH) && !queue_full;
   end

   always_comb begin
      if (block_len == '0) begin
         eff_blen = BW'(1);
      end else if (block_len > BW'(pswwm_pkg::MAX_BLOCK)) begin
         eff_blen = BW'(pswwm_pkg::MAX_BLOCK);
      end else begin
         eff_blen = block_len;
      end
      span     = (RW+1)'(read_len) + (RW+1)'(1) - (RW+1)'(eff_blen);
      in_range = (11'(read_len) <= 11'(MAX_READ));
      rtmp     = (BW+1)'({rem_ff, div_ff[RW-1]});
      ge       = (rtmp >= (BW+1)'(blen_ff));

      pat_in   = pat_ff;
      rlen_in  = rlen_ff;
      blen_in  = blen_ff;
      total_in = total_ff;
      cnt_in   = cnt_ff;
      last_in  = last_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      ok_in    = ok_ff;
      range_in = range_ff;

      if (state_ff == pswwm_pkg::F_IDLE && take) begin
         pat_in   = pswwm_pkg::swap_codes(pattern);
         rlen_in  = read_len;
         blen_in  = eff_blen;
         total_in = '0;
         cnt_in   = '0;
         last_in  = (eff_blen >= BW'(8)) ? PW'(eff_blen - 1'b1) : PW'(7);
         rem_in   = '0;
         quo_in   = '0;
         div_in   = span[RW-1:0];
         ok_in    = in_range && ((RW+1)'(read_len) + (RW+1)'(1) >= (RW+1)'({eff_blen, 1'b0}));
         range_in = in_range;
      end else if (state_ff == pswwm_pkg::F_CALC) begin
         if (BW'(cnt_ff) < blen_ff) begin
            total_in = TW'(total_ff + TW'(pswwm_pkg::weight_at(pat_ff, cnt_ff)));
         end
         if (cnt_ff < PW'(RW)) begin
            rem_in = ge ? PW'(rtmp - (BW+1)'(blen_ff)) : rtmp[PW-1:0];
            quo_in = {quo_ff[RW-2:0], ge};
            div_in = {div_ff[RW-2:0], 1'b0};
         end
         cnt_in = PW'(cnt_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pswwm_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      pat_ff   <= pat_in;
      rlen_ff  <= rlen_in;
      blen_ff  <= blen_in;
      total_ff <= total_in;
      cnt_ff   <= cnt_in;
      last_ff  <= last_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      div_ff   <= div_in;
      ok_ff    <= ok_in;
      range_ff <= range_in;
   end

   always_comb begin
      push_data.weights  = pat_ff;
      push_data.blen     = blen_ff;
      push_data.full     = quo_ff;
      push_data.rem      = rem_ff;
      push_data.total    = total_ff;
      push_data.rlen     = rlen_ff;
      push_data.ok       = ok_ff;
      push_data.in_range = range_ff;
   end

endmodule

FILE: src/pswwm_back.sv
// back part: circular window search, weight update in the best-weight store, result register
module pswwm_back #(
   parameter int MAX_READ = pswwm_pkg::MAX_READ
) (
   input  logic                clock,
   input  logic                reset,
   input  pswwm_pkg::job_type  job,
   input  logic                job_empty,
   output logic                pop,
   output logic                clearing,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [pswwm_pkg::WT_W-1:0] window_weight,
   output logic [pswwm_pkg::WT_W-1:0] best_weight,
   output logic                improved,
   output logic                accepted
);

   localparam int DEPTH = MAX_READ + 1;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW    = pswwm_pkg::POS_W;
   localparam int SW    = pswwm_pkg::TOTAL_W;
   localparam int WW    = pswwm_pkg::WT_W;
   localparam int MW    = pswwm_pkg::RLEN_W + pswwm_pkg::TOTAL_W;

   pswwm_pkg::back_state_type state_ff, state_in;
   pswwm_pkg::job_type job_ff, job_in;

   logic [WW-1:0] mem [DEPTH];
   logic [WW-1:0] rd_ff;

   logic [AW-1:0] clr_addr_ff;
   logic          clear_ff;

   logic [SW-1:0] sum_ff, sum_in;
   logic [SW-1:0] best_ff, best_in;
   logic [PW-1:0] p_ff, p_in;
   logic [PW-1:0] s_ff, s_in;
   logic [WW-1:0] weight_ff, weight_in;

   logic          rsp_valid_ff;
   logic [WW-1:0] win_out_ff, best_out_ff;
   logic          impr_out_ff, acc_out_ff;

   logic          out_free;
   logic          finish;
   logic          wr_en;
   logic [AW-1:0] addr;
   logic [WW-1:0] stored;
   logic          raise;
   logic [MW-1:0] prod;
   logic [MW-1:0] wsum;

   assign clearing      = clear_ff;
   assign rsp_tvalid    = rsp_valid_ff;
   assign window_weight = win_out_ff;
   assign best_weight   = best_out_ff;
   assign improved      = impr_out_ff;
   assign accepted      = acc_out_ff;
   assign out_free      = !rsp_valid_ff || rsp_tready;
   assign addr          = AW'(job_ff.rlen);
   assign stored        = job_ff.in_range ? rd_ff : '0;
   assign raise         = job_ff.ok && (weight_ff > stored);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pswwm_pkg::B_IDLE: begin
            if (!job_empty && !clear_ff) begin
               state_in = job.ok ? pswwm_pkg::B_INIT : pswwm_pkg::B_READ;
            end
         end
         pswwm_pkg::B_INIT: begin
            if (p_ff == job_ff.rem) state_in = pswwm_pkg::B_SLIDE;
         end
         pswwm_pkg::B_SLIDE: begin
            if (s_ff == PW'(job_ff.blen - 1'b1)) state_in = pswwm_pkg::B_READ;
         end
         pswwm_pkg::B_READ: state_in = pswwm_pkg::B_UPD;
         pswwm_pkg::B_UPD: begin
            if (out_free) state_in = pswwm_pkg::B_IDLE;
         end
         default: state_in = pswwm_pkg::B_IDLE;
      endcase
   end

   always_comb begin
      pop    = (state_ff == pswwm_pkg::B_IDLE) && !job_empty && !clear_ff;
      finish = (state_ff == pswwm_pkg::B_UPD) && out_free;
      wr_en  = finish && raise;
   end

   always_comb begin
      prod      = MW'(job_ff.full) * MW'(job_ff.total);
      wsum      = prod + MW'(best_ff);
      job_in    = job_ff;
      sum_in    = sum_ff;
      best_in   = best_ff;
      p_in      = p_ff;
      s_in      = s_ff;
      weight_in = weight_ff;
      case (state_ff)
         pswwm_pkg::B_IDLE: begin
            if (pop) begin
               job_in  = job;
               sum_in  = '0;
               best_in = '0;
               p_in    = '0;
               s_in    = '0;
            end
         end
         pswwm_pkg::B_INIT: begin
            if (p_ff != job_ff.rem) begin
               sum_in = SW'(sum_ff + SW'(pswwm_pkg::weight_at(job_ff.weights, p_ff)));
               p_in   = PW'(p_ff + 1'b1);
            end
         end
         pswwm_pkg::B_SLIDE: begin
            if (sum_ff > best_ff) best_in = sum_ff;
            sum_in = SW'(sum_ff + SW'(pswwm_pkg::weight_at(job_ff.weights, p_ff))
                     - SW'(pswwm_pkg::weight_at(job_ff.weights, s_ff)));
            p_in   = (p_ff == PW'(job_ff.blen - 1'b1)) ? '0 : PW'(p_ff + 1'b1);
            s_in   = PW'(s_ff + 1'b1);
         end
         pswwm_pkg::B_READ: begin
            weight_in = job_ff.ok ? wsum[WW-1:0] : '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pswwm_pkg::B_IDLE;
         clear_ff     <= 1'b1;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (clear_ff) begin
            clr_addr_ff <= AW'(clr_addr_ff + 1'b1);
            if (clr_addr_ff == AW'(DEPTH - 1)) clear_ff <= 1'b0;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      sum_ff    <= sum_in;
      best_ff   <= best_in;
      p_ff      <= p_in;
      s_ff      <= s_in;
      weight_ff <= weight_in;
      if (finish) begin
         win_out_ff  <= weight_ff;
         best_out_ff <= raise ? weight_ff : stored;
         impr_out_ff <= raise;
         acc_out_ff  <= job_ff.ok;
      end
   end

   always_ff @(posedge clock) begin
      if (clear_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[addr] <= weight_ff;
      end
      if (state_ff == pswwm_pkg::B_READ) begin
         rd_ff <= mem[addr];
      end
   end

   a_no_pop_clearing: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !pop)
      else $error("job taken during store clear");

   a_improved_needs_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(impr_out_ff && !acc_out_ff))
      else $error("improved set on rejected item");

   a_best_covers_weight: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && acc_out_ff) |-> (best_out_ff >= win_out_ff))
      else $error("stored best below item weight");

endmodule

FILE: src/periodic_seed_window_weight_max.sv
// top level of the periodic seed window weight block
//
//  port group | dir | payload
//  req_       | in  | tdata: pattern[63:0], read_len[71:64]
//  rsp_       | out | tdata: window_weight[9:0], best_weight[19:10], improved[20],
//             |     |        accepted[21], zero fill[23:22]
//  csr_       | in  | wr_data: block_len[5:0]
//
// front: per item, sums the block weight and runs an 8-step divider, then pushes the job
// back: accepted items pass through init, slide, read and update; rejected ones go to read and update
// front and back overlap through a two-entry queue, the slower one sets the rate
// after reset every store entry is cleared with req_tready low
// a stalled result waits in the output register while the next item is taken
module periodic_seed_window_weight_max #(
   parameter int MAX_READ = pswwm_pkg::MAX_READ
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // pattern, read_len
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // window_weight, best_weight, improved, accepted
   input  logic        csr_wr_en,
   input  logic [5:0]  csr_wr_data
);

   logic [pswwm_pkg::BLEN_W-1:0] block_len_ff;

   logic               push;
   logic               pop;
   logic               queue_full;
   logic               queue_empty;
   logic               clearing;
   pswwm_pkg::job_type push_data;
   pswwm_pkg::job_type pop_data;

   logic [pswwm_pkg::WT_W-1:0] window_weight;
   logic [pswwm_pkg::WT_W-1:0] best_weight;
   logic                       improved;
   logic                       accepted;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_len_ff <= pswwm_pkg::BLEN_RESET;
      end else if (csr_wr_en) begin
         block_len_ff <= csr_wr_data;
      end
   end

   pswwm_front #(
      .MAX_READ (MAX_READ)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .hold       (clearing),
      .block_len  (block_len_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .pattern    (req_tdata[63:0]),
      .read_len   (req_tdata[71:64]),
      .push       (push),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   pswwm_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   pswwm_back #(
      .MAX_READ (MAX_READ)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .job           (pop_data),
      .job_empty     (queue_empty),
      .pop           (pop),
      .clearing      (clearing),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .window_weight (window_weight),
      .best_weight   (best_weight),
      .improved      (improved),
      .accepted      (accepted)
   );

   assign rsp_tdata = {2'b00, accepted, improved, best_weight, window_weight};

endmodule

FILE: test/testbench.sv
// testbench for the periodic seed window weight block: predicted weights checked on every result
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT   = 5000;
   localparam int DRAIN_CYCLES = 200;
   localparam int PHASE_ITEMS  = 80;
   localparam int PW           = pswwm_pkg::PAT_W;
   localparam int RW           = pswwm_pkg::RLEN_W;
   localparam int BW           = pswwm_pkg::BLEN_W;
   localparam int WW           = pswwm_pkg::WT_W;

   typedef struct packed {
      logic          accepted;
      logic          improved;
      logic [WW-1:0] best_weight;
      logic [WW-1:0] window_weight;
   } weight_result_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_RANDOM,
      READY_SPARSE,
      READY_PERIODIC
   } ready_mode_type;

   class weight_scoreboard;
      logic [WW-1:0]     best_store [pswwm_pkg::MAX_READ+1];
      logic [BW-1:0]     block_len;
      weight_result_type expected_q [$];
      int                errors;

      function new();
         foreach (best_store[i]) best_store[i] = '0;
         block_len = pswwm_pkg::BLEN_RESET;
         errors = 0;
      endfunction

      function int unsigned eff_len();
         if (block_len == 0) return 1;
         if (block_len > BW'(pswwm_pkg::MAX_BLOCK)) return pswwm_pkg::MAX_BLOCK;
         return 32'(block_len);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // predict the weight of one accepted item and update the best-weight store
      function void note_request(input logic [PW-1:0] pattern,
                                 input logic [RW-1:0] read_len);
         int unsigned       b, total, span, full, rem, best_win, sum, p, weight;
         int unsigned       wt [pswwm_pkg::MAX_BLOCK];
         weight_result_type res;
         b = eff_len();
         total = 0;
         best_win = 0;
         for (int k = 0; k < b; k++) begin
            wt[k] = 32'({pattern[2*k], pattern[2*k+1]});
            total += wt[k];
         end
         res = '0;
         if (32'(read_len) + 1 < 2 * b) begin
            res.best_weight = best_store[read_len];
         end else begin
            span = 32'(read_len) + 1 - b;
            full = span / b;
            rem  = span % b;
            for (int s = 0; s < b; s++) begin
               sum = 0;
               p = s;
               for (int i = 0; i < rem; i++) begin
                  sum += wt[p];
                  p = (p + 1 >= b) ? 0 : p + 1;
               end
               if (sum > best_win) best_win = sum;
            end
            weight = (full * total + best_win) & 32'h3FF;
            res.window_weight = WW'(weight);
            res.accepted = 1'b1;
            if (32'(best_store[read_len]) < weight) begin
               best_store[read_len] = WW'(weight);
               res.improved = 1'b1;
            end
            res.best_weight = best_store[read_len];
         end
         expected_q.push_back(res);
      endfunction

      function void compare_field(input string name, input int unsigned exp_val,
                                  input int unsigned act_val);
         if (exp_val != act_val) begin
            $display("%0t %s: expected %0d actual %0d", $time, name, exp_val, act_val);
            errors++;
         end
      endfunction

      function void check_response(input logic [23:0] data);
         weight_result_type act, exp_res;
         act = data[21:0];
         if (expected_q.size() == 0) begin
            $display("%0t result with no item waiting: expected none actual %h", $time, act);
            errors++;
         end else begin
            exp_res = expected_q.pop_front();
            compare_field("window_weight", 32'(exp_res.window_weight),
                          32'(act.window_weight));
            compare_field("best_weight", 32'(exp_res.best_weight), 32'(act.best_weight));
            compare_field("improved", 32'(exp_res.improved), 32'(act.improved));
            compare_field("accepted", 32'(exp_res.accepted), 32'(act.accepted));
         end
      endfunction
   endclass

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata   = '0;   // pattern, read_len
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [23:0] rsp_tdata;          // window_weight, best_weight, improved, accepted
   logic        csr_wr_en   = 1'b0;
   logic [5:0]  csr_wr_data = '0;

   weight_scoreboard sb;
   int unsigned      burst_left = 0;
   ready_mode_type   ready_mode = READY_ALWAYS;
   int unsigned      ready_left = 0;
   int unsigned      cycle_count = 0;
   int unsigned      idle_cycles = 0;
   int               blen_seq [10] = '{1, 32, 0, 63, 33, 2, 17, 5, 3, 8};

   periodic_seed_window_weight_max i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver stalls in stretches of changing pattern
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (ready_left == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(0, 3));
         ready_left <= $urandom_range(16, 256);
      end else begin
         ready_left <= ready_left - 1;
      end
      case (ready_mode)
         READY_ALWAYS:   rsp_tready <= 1'b1;
         READY_RANDOM:   rsp_tready <= ($urandom_range(0, 1) == 1);
         READY_SPARSE:   rsp_tready <= ($urandom_range(0, 7) == 0);
         READY_PERIODIC: rsp_tready <= cycle_count[2];
         default:        rsp_tready <= 1'b1;
      endcase
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_request(req_tdata[63:0], req_tdata[71:64]);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   task automatic send_item(input logic [PW-1:0] pattern, input logic [RW-1:0] read_len);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {read_len, pattern};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic write_block_len(input logic [BW-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.block_len = value;
   endtask

   task automatic run_phase(input int n_random);
      int unsigned   b, lo, pick;
      logic [RW-1:0] rlen;
      logic [PW-1:0] pat;
      logic [RW-1:0] pool [4];
      b  = sb.eff_len();
      lo = 2 * b - 1;
      // one short of a whole block, exactly one block, longest read
      send_item({$urandom, $urandom}, RW'(lo - 1));
      send_item({$urandom, $urandom}, RW'(lo));
      send_item('1, 8'd255);
      pool[0] = RW'(lo);
      pool[1] = RW'(lo + $urandom_range(0, 2 * b));
      pool[2] = 8'd255;
      pool[3] = RW'($urandom_range(lo, 255));
      repeat (n_random) begin
         pick = $urandom_range(0, 9);
         if (pick == 0)      rlen = RW'($urandom_range(0, 255));
         else if (pick == 1) rlen = RW'($urandom_range(0, lo));
         else if (pick < 5)  rlen = pool[$urandom_range(0, 3)];
         else                rlen = RW'($urandom_range(lo, 255));
         pick = $urandom_range(0, 5);
         if (pick == 0)      pat = {$urandom, $urandom} & {$urandom, $urandom};
         else if (pick == 1) pat = {$urandom, $urandom} | {$urandom, $urandom};
         else if (pick == 2) pat = '1;
         else                pat = {$urandom, $urandom};
         send_item(pat, rlen);
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // reset block length of four
      send_item(64'h0, 8'd255);
      send_item('1, 8'd255);
      send_item('1, 8'd255);
      send_item(64'h0, 8'd0);
      send_item('1, 8'd1);
      send_item('1, 8'd6);
      send_item(64'h5555_5555_5555_5555, 8'd7);
      send_item(64'hAAAA_AAAA_AAAA_AAAA, 8'd7);
      send_item(64'h0000_0000_0000_00E4, 8'd8);
      send_item(64'h0000_0000_0000_00E4, 8'd9);
      send_item(64'h0000_0000_0000_001B, 8'd10);
      send_item(64'hFFFF_FFFF_FFFF_FF00, 8'd254);
      send_item(64'h0000_0000_0000_00FF, 8'd254);
      send_item(64'h8000_0000_0000_0001, 8'd128);
      run_phase(PHASE_ITEMS);
      foreach (blen_seq[i]) begin
         write_block_len(BW'(blen_seq[i]));
         run_phase(PHASE_ITEMS);
      end
      repeat (2) begin
         write_block_len(BW'($urandom_range(0, 63)));
         run_phase(PHASE_ITEMS);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
